// File: hdl/lkv_pkg.sv
package lkv_pkg;

    localparam int KEY_W           = 32;
    localparam int VAL_W           = 32;
    localparam int CAP_W           = 5;
    localparam int MAX_ENTRIES_DEF = 16;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // operation codes carried in the op field
    localparam logic OP_GET = 1'b0;
    localparam logic OP_PUT = 1'b1;

    typedef struct packed {
        logic                    op;
        logic signed [KEY_W-1:0] lookup_key;
        logic signed [VAL_W-1:0] write_value;
    } req_t;

    typedef struct packed {
        logic                    found;
        logic signed [VAL_W-1:0] read_value;
    } rsp_t;

    typedef logic [CAP_W-1:0] cfg_t;

    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic signed [VAL_W-1:0] value;
    } entry_t;

    typedef struct packed {
        logic cmp_en;
        logic valid;
        logic shift_en;
    } cell_ctrl_t;

endpackage

// File: hdl/lkv_chan_if.sv
interface lkv_chan_if #(parameter type payload_t = logic);

    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);

endinterface

// File: hdl/lkv_cell.sv
module lkv_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  lkv_pkg::cell_ctrl_t ctrl,
    input  lkv_pkg::entry_t    shift_in,
    input  logic signed [lkv_pkg::KEY_W-1:0] cmp_key,
    output lkv_pkg::entry_t    entry,
    output logic               match
);
    import lkv_pkg::*;

    entry_t entry_reg;
    logic   match_reg;

    // take the neighbor's entry when the row shifts through this cell
    always_ff @(posedge clk)
    begin
        if (ctrl.shift_en)
        begin
            entry_reg <= shift_in;
        end
    end

    // compare against the incoming key when a beat is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= 1'b0;
        end
        else if (ctrl.cmp_en)
        begin
            match_reg <= ctrl.valid && (entry_reg.key == cmp_key);
        end
    end

    assign entry = entry_reg;
    assign match = match_reg;

endmodule

// File: hdl/lkv_hit_reduce.sv
module lkv_hit_reduce #(
    parameter int MAX_ENTRIES = lkv_pkg::MAX_ENTRIES_DEF,
    parameter int CNT_W       = $clog2(MAX_ENTRIES + 1)
) (
    input  logic [MAX_ENTRIES-1:0] match,
    input  lkv_pkg::entry_t        entries [MAX_ENTRIES],
    output logic                   hit,
    output logic [CNT_W-1:0]       hit_idx,
    output logic signed [lkv_pkg::VAL_W-1:0] hit_value
);
    import lkv_pkg::*;

    // at most one cell matches, so plain OR trees encode position and value
    always_comb
    begin
        hit_idx   = '0;
        hit_value = '0;
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            if (match[i])
            begin
                hit_idx   = hit_idx | CNT_W'(i);
                hit_value = hit_value | entries[i].value;
            end
        end
    end

    assign hit = |match;

endmodule

// File: hdl/lru_key_value_cache.sv
// The result beat is registered and is raised after the update cycle of its request.
// A new request is not taken until that update is done; the cell row compares keys in the
// accept cycle and shifts entries toward the tail in the following update cycle.
// A result beat still waiting on the output holds the update cycle until it is taken.
// Reset: the store is empty (fill count zero), capacity register reads 16,
// entry contents are left as they are and need no clearing pass.
module lru_key_value_cache #(
    parameter int MAX_ENTRIES = lkv_pkg::MAX_ENTRIES_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    lkv_chan_if.sink   req,
    lkv_chan_if.source rsp,
    lkv_chan_if.sink   cfg
);
    import lkv_pkg::*;

    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_UPD  = 2'b10
    } state_t;

    state_t             state_reg, state_next;
    req_t               item_reg;
    logic [CNT_W-1:0]   count_reg, count_next;
    cfg_t               cap_reg;
    logic               rsp_valid_reg, rsp_valid_next;
    rsp_t               rsp_data_reg, rsp_data_next;

    entry_t             cell_entry [MAX_ENTRIES];
    entry_t             cell_in    [MAX_ENTRIES];
    cell_ctrl_t         cell_ctrl  [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0] match_vec;

    logic               hit;
    logic [CNT_W-1:0]   hit_idx;
    logic signed [VAL_W-1:0] hit_value;
    logic [CNT_W-1:0]   cap_eff;
    logic               evict;
    logic [CNT_W-1:0]   shift_top;
    logic               accept;
    logic               upd_go;
    logic               do_write;
    entry_t             head_entry;

    assign accept   = req.valid && req.ready;
    assign req.ready = (state_reg == S_IDLE);
    assign cfg.ready = 1'b1;
    assign upd_go   = (state_reg == S_UPD) && (!rsp_valid_reg || rsp.ready);

    // clamp the capacity register into 1 .. MAX_ENTRIES
    always_comb
    begin
        if (cap_reg == '0)
        begin
            cap_eff = CNT_W'(1);
        end
        else if ({27'b0, cap_reg} > 32'(MAX_ENTRIES))
        begin
            cap_eff = CNT_W'(MAX_ENTRIES);
        end
        else
        begin
            cap_eff = CNT_W'(cap_reg);
        end
    end

    lkv_hit_reduce #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .CNT_W       (CNT_W)
    ) u_reduce (
        .match     (match_vec),
        .entries   (cell_entry),
        .hit       (hit),
        .hit_idx   (hit_idx),
        .hit_value (hit_value)
    );

    // pick the deepest cell that shifts and the new head entry
    always_comb
    begin
        evict    = (count_reg >= cap_eff);
        do_write = hit || (item_reg.op == OP_PUT);
        if (hit)
        begin
            shift_top = hit_idx;
        end
        else if (evict)
        begin
            shift_top = count_reg - CNT_W'(1);
        end
        else
        begin
            shift_top = count_reg;
        end
        head_entry.key   = item_reg.lookup_key;
        head_entry.value = (item_reg.op == OP_PUT) ? item_reg.write_value : hit_value;
    end

    // build the row: cell 0 gets the new head, others take their neighbor
    for (genvar i = 0; i < MAX_ENTRIES; i++)
    begin : g_cell
        if (i == 0)
        begin : g_head
            assign cell_in[i] = head_entry;
        end
        else
        begin : g_body
            assign cell_in[i] = cell_entry[i-1];
        end

        assign cell_ctrl[i].cmp_en   = accept;
        assign cell_ctrl[i].valid    = (CNT_W'(i) < count_reg);
        assign cell_ctrl[i].shift_en = upd_go && do_write && (CNT_W'(i) <= shift_top);

        lkv_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (cell_ctrl[i]),
            .shift_in (cell_in[i]),
            .cmp_key  (req.payload.lookup_key),
            .entry    (cell_entry[i]),
            .match    (match_vec[i])
        );
    end

    // sequence accept and update, track fill count, load the result
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_data_next  = rsp_data_reg;
        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_UPD;
                end
            end
            S_UPD:
            begin
                if (upd_go)
                begin
                    state_next               = S_IDLE;
                    rsp_valid_next           = 1'b1;
                    rsp_data_next.found      = hit;
                    rsp_data_next.read_value =
                        (hit && (item_reg.op == OP_GET)) ? hit_value : '0;
                    if (!hit && (item_reg.op == OP_PUT) && !evict)
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            cap_reg       <= CAP_RESET;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg.valid)
            begin
                cap_reg <= cfg.payload;
            end
        end
    end

    // hold the request and result payloads
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= req.payload;
        end
        rsp_data_reg <= rsp_data_next;
    end

    assign rsp.valid   = rsp_valid_reg;
    assign rsp.payload = rsp_data_reg;

    // a result appears only after an update cycle
    a_rsp_after_upd: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == S_UPD))
        else $error("result raised without an update cycle");

    // keys in the row stay unique
    a_single_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_UPD) |-> $onehot0(match_vec))
        else $error("more than one cell matched the key");

    // fill count never passes the row length
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_ENTRIES))
        else $error("fill count beyond row length");

    // a full store keeps its count across an update
    a_full_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (upd_go && evict) |=> (count_reg == $past(count_reg)))
        else $error("fill count grew on a full store");

    // no request is taken while an update is pending
    a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_UPD) |-> !accept)
        else $error("request taken during update");

endmodule
